// File: sv/hssd_pkg.sv
// Shared types, tag codes and helpers for the Hessian 2 scalar stream decoder.
package hssd_pkg;

	typedef enum logic [1:0] {
		PH_TAG    = 2'd0,
		PH_SCALAR = 2'd1,
		PH_LENGTH = 2'd2,
		PH_DATA   = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		K_INT      = 4'd0,
		K_LONG     = 4'd1,
		K_DINT     = 4'd2,
		K_DMILLI   = 4'd3,
		K_DBITS    = 4'd4,
		K_BOOL     = 4'd5,
		K_NULL     = 4'd6,
		K_DATE_MS  = 4'd7,
		K_DATE_MIN = 4'd8,
		K_STR      = 4'd9,
		K_BIN      = 4'd10,
		K_UNSUP    = 4'd11
	} kind_t;

	localparam logic [7:0] TAG_BIN_MORE   = 8'h41;
	localparam logic [7:0] TAG_BIN_FINAL  = 8'h42;
	localparam logic [7:0] TAG_DBL_BITS   = 8'h44;
	localparam logic [7:0] TAG_FALSE      = 8'h46;
	localparam logic [7:0] TAG_INT32      = 8'h49;
	localparam logic [7:0] TAG_DATE_MS    = 8'h4A;
	localparam logic [7:0] TAG_DATE_MIN   = 8'h4B;
	localparam logic [7:0] TAG_LONG64     = 8'h4C;
	localparam logic [7:0] TAG_NULL       = 8'h4E;
	localparam logic [7:0] TAG_STR_MORE   = 8'h52;
	localparam logic [7:0] TAG_STR_FINAL  = 8'h53;
	localparam logic [7:0] TAG_TRUE       = 8'h54;
	localparam logic [7:0] TAG_LONG32     = 8'h59;
	localparam logic [7:0] TAG_DBL_ZERO   = 8'h5B;
	localparam logic [7:0] TAG_DBL_ONE    = 8'h5C;
	localparam logic [7:0] TAG_DBL_BYTE   = 8'h5D;
	localparam logic [7:0] TAG_DBL_SHORT  = 8'h5E;
	localparam logic [7:0] TAG_DBL_MILLI  = 8'h5F;

	localparam logic [7:0] BASE_INT1  = 8'h90;
	localparam logic [7:0] BASE_INT2  = 8'hC8;
	localparam logic [7:0] BASE_INT3  = 8'hD4;
	localparam logic [7:0] BASE_LONG1 = 8'hE0;
	localparam logic [7:0] BASE_LONG2 = 8'hF8;
	localparam logic [7:0] BASE_LONG3 = 8'h3C;
	localparam logic [7:0] BASE_BLEN  = 8'h34;
	localparam logic [7:0] BASE_SLEN  = 8'h30;
	localparam logic [7:0] BASE_BIN0  = 8'h20;

	localparam logic signed [16:0] MS_PER_MIN = 17'sd60000;

	function automatic kind_t chunk_kind(input logic [7:0] t);
		if (t < 8'h20 || (t >= 8'h30 && t <= 8'h33) || t == TAG_STR_MORE ||
				t == TAG_STR_FINAL)
			return K_STR;
		return K_BIN;
	endfunction

	// t - c, sign-extended to 64 bits
	function automatic logic [63:0] sub_ext(input logic [7:0] t, input logic [7:0] c);
		logic [8:0] d;
		d = {1'b0, t} - {1'b0, c};
		return {{55{d[8]}}, d};
	endfunction

endpackage

// File: sv/hessian_scalar_stream_decoder_core.sv
// Hessian 2 byte stream decoder: tags and operand bytes in, typed scalars and chunk bytes out.
//
// Input channel: one stream byte per request on data_byte, in_valid/in_ready.
// Output channel: one result per request on value_kind, value, chunk_last,
// chunk_final, chunk_empty, with out_valid/out_ready.
// Each accepted byte yields zero or one result. A tag that stands alone, the
// last operand byte of a scalar, every string or binary payload byte and an
// empty chunk header each give one result; other bytes give none.
// The result is registered: it appears on the output register in the cycle
// after the byte that completes it is accepted.
// Throughput: one byte per cycle while in_ready is high; the decode state and
// the 32x17 minute-date multiply sit between the state registers and the output register.
// While the output register holds a result the receiver has not taken,
// in_ready drops; it stays high whenever the register is empty or drained.
// Reset clears the output valid flag and returns the decoder to expecting a
// tag byte with its gathered operand and counts cleared.
module hessian_scalar_stream_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  value_kind,
	output logic [63:0] value,
	output logic        chunk_last,
	output logic        chunk_final,
	output logic        chunk_empty
);

	hssd_pkg::phase_t phase_q, phase_d;
	logic [7:0]  tag_q, tag_d;
	logic [15:0] left_q, left_d, left_dec;
	logic [63:0] acc_q, acc_d, acc_sh;
	logic        fin_q, fin_d;

	logic              res_v;
	hssd_pkg::kind_t   res_kind;
	logic [63:0]       res_val;
	logic              res_last, res_fin, res_empty;

	hssd_pkg::kind_t   sc_kind;
	logic [63:0]       sc_val;
	logic signed [31:0] min_s;
	logic signed [48:0] min_ms;

	logic              out_valid_q;
	hssd_pkg::kind_t   kind_q;
	logic [63:0]       value_q;
	logic              last_q, final_q, empty_q;

	logic accept;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign left_dec = (left_q != 16'd0) ? left_q - 16'd1 : 16'd0;
	assign acc_sh   = {acc_q[55:0], data_byte};
	assign min_s    = $signed(acc_sh[31:0]);
	assign min_ms   = min_s * hssd_pkg::MS_PER_MIN;

	// scalar completion from the held tag and the fully gathered operand
	always_comb begin
		sc_kind = hssd_pkg::K_UNSUP;
		sc_val  = {56'd0, tag_q};
		case (tag_q)
			hssd_pkg::TAG_DBL_BITS: begin
				sc_kind = hssd_pkg::K_DBITS;
				sc_val  = acc_sh;
			end
			hssd_pkg::TAG_LONG64: begin
				sc_kind = hssd_pkg::K_LONG;
				sc_val  = acc_sh;
			end
			hssd_pkg::TAG_DATE_MS: begin
				sc_kind = hssd_pkg::K_DATE_MS;
				sc_val  = acc_sh;
			end
			hssd_pkg::TAG_DATE_MIN: begin
				sc_kind = hssd_pkg::K_DATE_MIN;
				sc_val  = {{15{min_ms[48]}}, min_ms};
			end
			hssd_pkg::TAG_INT32: begin
				sc_kind = hssd_pkg::K_INT;
				sc_val  = {{32{acc_sh[31]}}, acc_sh[31:0]};
			end
			hssd_pkg::TAG_LONG32: begin
				sc_kind = hssd_pkg::K_LONG;
				sc_val  = {{32{acc_sh[31]}}, acc_sh[31:0]};
			end
			hssd_pkg::TAG_DBL_BYTE: begin
				sc_kind = hssd_pkg::K_DINT;
				sc_val  = {{56{acc_sh[7]}}, acc_sh[7:0]};
			end
			hssd_pkg::TAG_DBL_SHORT: begin
				sc_kind = hssd_pkg::K_DINT;
				sc_val  = {{48{acc_sh[15]}}, acc_sh[15:0]};
			end
			hssd_pkg::TAG_DBL_MILLI: begin
				sc_kind = hssd_pkg::K_DMILLI;
				sc_val  = {{32{acc_sh[31]}}, acc_sh[31:0]};
			end
			default: begin
				if (tag_q >= 8'h38 && tag_q <= 8'h3F) begin
					sc_kind = hssd_pkg::K_LONG;
					sc_val  = acc_sh;
				end else if (tag_q >= 8'hC0 && tag_q <= 8'hD7) begin
					sc_kind = hssd_pkg::K_INT;
					sc_val  = acc_sh;
				end else if (tag_q >= 8'hF0) begin
					sc_kind = hssd_pkg::K_LONG;
					sc_val  = acc_sh;
				end
			end
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		tag_d     = tag_q;
		left_d    = left_q;
		acc_d     = acc_q;
		fin_d     = fin_q;
		res_v     = 1'b0;
		res_kind  = hssd_pkg::K_UNSUP;
		res_val   = 64'd0;
		res_last  = 1'b0;
		res_fin   = 1'b0;
		res_empty = 1'b0;
		case (phase_q)
			hssd_pkg::PH_SCALAR, hssd_pkg::PH_LENGTH: begin
				acc_d  = acc_sh;
				left_d = left_dec;
				if (left_dec == 16'd0) begin
					if (phase_q == hssd_pkg::PH_SCALAR) begin
						phase_d  = hssd_pkg::PH_TAG;
						res_v    = 1'b1;
						res_kind = sc_kind;
						res_val  = sc_val;
					end else if (acc_sh[15:0] == 16'd0) begin
						phase_d   = hssd_pkg::PH_TAG;
						res_v     = 1'b1;
						res_kind  = hssd_pkg::chunk_kind(tag_q);
						res_last  = 1'b1;
						res_fin   = fin_q;
						res_empty = 1'b1;
					end else begin
						left_d  = acc_sh[15:0];
						phase_d = hssd_pkg::PH_DATA;
					end
				end
			end
			hssd_pkg::PH_DATA: begin
				left_d   = left_dec;
				res_v    = 1'b1;
				res_kind = hssd_pkg::chunk_kind(tag_q);
				res_val  = {56'd0, data_byte};
				res_last = (left_dec == 16'd0);
				res_fin  = fin_q;
				if (left_dec == 16'd0)
					phase_d = hssd_pkg::PH_TAG;
			end
			default: begin
				tag_d   = data_byte;
				fin_d   = 1'b1;
				acc_d   = 64'd0;
				left_d  = 16'd0;
				phase_d = hssd_pkg::PH_TAG;
				if (data_byte < hssd_pkg::BASE_BIN0 || data_byte < hssd_pkg::BASE_SLEN) begin
					// compact chunk: length in the tag itself
					if ((data_byte < hssd_pkg::BASE_BIN0 && data_byte[4:0] == 5'd0) ||
							data_byte == hssd_pkg::BASE_BIN0) begin
						res_v     = 1'b1;
						res_kind  = hssd_pkg::chunk_kind(data_byte);
						res_last  = 1'b1;
						res_fin   = 1'b1;
						res_empty = 1'b1;
					end else begin
						left_d  = (data_byte < hssd_pkg::BASE_BIN0) ?
							{11'd0, data_byte[4:0]} : {12'd0, data_byte[3:0]};
						phase_d = hssd_pkg::PH_DATA;
					end
				end else if (data_byte < 8'h38) begin
					acc_d   = {62'd0, data_byte[1:0]};
					left_d  = 16'd1;
					phase_d = hssd_pkg::PH_LENGTH;
				end else if (data_byte < 8'h40) begin
					acc_d   = hssd_pkg::sub_ext(data_byte, hssd_pkg::BASE_LONG3);
					left_d  = 16'd2;
					phase_d = hssd_pkg::PH_SCALAR;
				end else if (data_byte >= 8'h80 && data_byte <= 8'hBF) begin
					res_v    = 1'b1;
					res_kind = hssd_pkg::K_INT;
					res_val  = hssd_pkg::sub_ext(data_byte, hssd_pkg::BASE_INT1);
				end else if (data_byte >= 8'hC0 && data_byte <= 8'hCF) begin
					acc_d   = hssd_pkg::sub_ext(data_byte, hssd_pkg::BASE_INT2);
					left_d  = 16'd1;
					phase_d = hssd_pkg::PH_SCALAR;
				end else if (data_byte >= 8'hD0 && data_byte <= 8'hD7) begin
					acc_d   = hssd_pkg::sub_ext(data_byte, hssd_pkg::BASE_INT3);
					left_d  = 16'd2;
					phase_d = hssd_pkg::PH_SCALAR;
				end else if (data_byte >= 8'hD8 && data_byte <= 8'hEF) begin
					res_v    = 1'b1;
					res_kind = hssd_pkg::K_LONG;
					res_val  = hssd_pkg::sub_ext(data_byte, hssd_pkg::BASE_LONG1);
				end else if (data_byte >= 8'hF0) begin
					acc_d   = hssd_pkg::sub_ext(data_byte, hssd_pkg::BASE_LONG2);
					left_d  = 16'd1;
					phase_d = hssd_pkg::PH_SCALAR;
				end else begin
					case (data_byte)
						hssd_pkg::TAG_BIN_MORE, hssd_pkg::TAG_STR_MORE: begin
							fin_d   = 1'b0;
							left_d  = 16'd2;
							phase_d = hssd_pkg::PH_LENGTH;
						end
						hssd_pkg::TAG_BIN_FINAL, hssd_pkg::TAG_STR_FINAL: begin
							left_d  = 16'd2;
							phase_d = hssd_pkg::PH_LENGTH;
						end
						hssd_pkg::TAG_DBL_BITS, hssd_pkg::TAG_DATE_MS,
						hssd_pkg::TAG_LONG64: begin
							left_d  = 16'd8;
							phase_d = hssd_pkg::PH_SCALAR;
						end
						hssd_pkg::TAG_INT32, hssd_pkg::TAG_DATE_MIN,
						hssd_pkg::TAG_LONG32, hssd_pkg::TAG_DBL_MILLI: begin
							left_d  = 16'd4;
							phase_d = hssd_pkg::PH_SCALAR;
						end
						hssd_pkg::TAG_DBL_BYTE: begin
							left_d  = 16'd1;
							phase_d = hssd_pkg::PH_SCALAR;
						end
						hssd_pkg::TAG_DBL_SHORT: begin
							left_d  = 16'd2;
							phase_d = hssd_pkg::PH_SCALAR;
						end
						hssd_pkg::TAG_FALSE: begin
							res_v    = 1'b1;
							res_kind = hssd_pkg::K_BOOL;
						end
						hssd_pkg::TAG_TRUE: begin
							res_v    = 1'b1;
							res_kind = hssd_pkg::K_BOOL;
							res_val  = 64'd1;
						end
						hssd_pkg::TAG_NULL: begin
							res_v    = 1'b1;
							res_kind = hssd_pkg::K_NULL;
						end
						hssd_pkg::TAG_DBL_ZERO: begin
							res_v    = 1'b1;
							res_kind = hssd_pkg::K_DINT;
						end
						hssd_pkg::TAG_DBL_ONE: begin
							res_v    = 1'b1;
							res_kind = hssd_pkg::K_DINT;
							res_val  = 64'd1;
						end
						default: begin
							res_v    = 1'b1;
							res_kind = hssd_pkg::K_UNSUP;
							res_val  = {56'd0, data_byte};
						end
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hssd_pkg::PH_TAG;
			tag_q   <= 8'd0;
			left_q  <= 16'd0;
			acc_q   <= 64'd0;
			fin_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			tag_q   <= tag_d;
			left_q  <= left_d;
			acc_q   <= acc_d;
			fin_q   <= fin_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (in_ready)
			out_valid_q <= accept && res_v;
	end

	always_ff @(posedge clk) begin
		if (accept && res_v) begin
			kind_q  <= res_kind;
			value_q <= res_val;
			last_q  <= res_last;
			final_q <= res_fin;
			empty_q <= res_empty;
		end
	end

	assign out_valid   = out_valid_q;
	assign value_kind  = kind_q;
	assign value       = value_q;
	assign chunk_last  = last_q;
	assign chunk_final = final_q;
	assign chunk_empty = empty_q;

`ifndef SYNTHESIS
	a_chunk_flags_only_on_chunks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !(kind_q == hssd_pkg::K_STR || kind_q == hssd_pkg::K_BIN)
		|-> !(last_q || final_q || empty_q))
		else $error("chunk flags set on a scalar result");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && empty_q |-> last_q)
		else $error("empty chunk result without chunk_last");

	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != hssd_pkg::PH_TAG |-> left_q != 16'd0)
		else $error("operand or payload phase with zero bytes left");

	a_data_byte_emits: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == hssd_pkg::PH_DATA |=> out_valid_q)
		else $error("payload byte accepted without a result");
`endif

endmodule
